@@ src/median5_setpoint_filter_unit_defines.svh @@
// assertion macros for the median-of-five setpoint filter
// no dependencies; included by the modules that carry assertions
`ifndef MEDIAN5_SETPOINT_FILTER_UNIT_DEFINES_SVH
`define MEDIAN5_SETPOINT_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define M5SF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define M5SF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/m5sf_pkg.sv @@
// types, constants and scaling tables for the median-of-five setpoint filter
// no dependencies; imported by m5sf_sort and median5_setpoint_filter_unit
`timescale 1ns / 1ps

package m5sf_pkg;

   localparam int WINDOW_LEN = 5;
   localparam int SAMPLE_W   = 8;
   localparam int PWM_W      = 10;
   localparam int RPM_W      = 12;
   localparam int SLOT_W     = 3;
   localparam int MED_IDX    = WINDOW_LEN / 2;
   localparam int LUT_DEPTH  = 2 ** SAMPLE_W;

   localparam int PWM_NUM  = 24;
   localparam int PWM_DEN  = 10;
   localparam int RPM_BASE = 650;
   localparam int RPM_NUM  = 107843;
   localparam int RPM_DEN  = 10000;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [PWM_W-1:0]    pwm_type;
   typedef logic [RPM_W-1:0]    rpm_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_type;

   // sorter passes and ring positions
   typedef logic [1:0] pass_type;
   typedef logic [2:0] pos_type;
   localparam pass_type PASS_LAST = pass_type'(MED_IDX);
   localparam pos_type  POS_LAST  = pos_type'(WINDOW_LEN - 1);

   typedef struct packed {
      logic start;
   } sort_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sort_stat_type;

   typedef pwm_type pwm_lut_type [LUT_DEPTH];
   typedef rpm_type rpm_lut_type [LUT_DEPTH];

   function automatic pwm_lut_type build_pwm_lut();
      pwm_lut_type lut;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         lut[i] = pwm_type'((i * PWM_NUM) / PWM_DEN);
      end
      return lut;
   endfunction

   function automatic rpm_lut_type build_rpm_lut();
      rpm_lut_type lut;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         lut[i] = rpm_type'(RPM_BASE + (i * RPM_NUM) / RPM_DEN);
      end
      return lut;
   endfunction

   localparam pwm_lut_type PWM_LUT = build_pwm_lut();
   localparam rpm_lut_type RPM_LUT = build_rpm_lut();

endpackage

@@ src/m5sf_sort.sv @@
// iterative median finder: five-entry ring with one shared compare-swap unit
// depends on m5sf_pkg and median5_setpoint_filter_unit_defines.svh
`timescale 1ns / 1ps
`include "median5_setpoint_filter_unit_defines.svh"

module m5sf_sort
   import m5sf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sort_ctrl_type sort_ctrl,
   input  window_type    window,
   output sort_stat_type sort_stat,
   output sample_type    median
);

   window_type ring_ff, ring_in;
   pass_type   pass_ff, pass_in;
   pos_type    pos_ff, pos_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;

   logic       cmp_en;
   sample_type lo_val;
   sample_type hi_val;
   logic       a_gt_b;

   // compare-swap at ring slots 0 and 1 while the position is below the pass limit, then rotate by one
   assign cmp_en = pos_ff < (POS_LAST - pos_type'(pass_ff));
   assign a_gt_b = ring_ff[0] > ring_ff[1];
   assign lo_val = (cmp_en && a_gt_b) ? ring_ff[1] : ring_ff[0];
   assign hi_val = (cmp_en && a_gt_b) ? ring_ff[0] : ring_ff[1];

   always_comb begin
      ring_in = ring_ff;
      pass_in = pass_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (sort_ctrl.start) begin
         ring_in = window;
         pass_in = '0;
         pos_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < WINDOW_LEN - 2; i++) begin
            ring_in[i + 1] = ring_ff[i + 2];
         end
         ring_in[0]              = hi_val;
         ring_in[WINDOW_LEN - 1] = lo_val;
         if (pos_ff == POS_LAST) begin
            pos_in  = '0;
            pass_in = pass_ff + pass_type'(1);
            if (pass_ff == PASS_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            pos_in = pos_ff + pos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
      pass_ff <= pass_in;
      pos_ff  <= pos_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sort_stat.busy = busy_ff;
   assign sort_stat.done = done_ff;
   assign median         = ring_ff[MED_IDX];

   `M5SF_ASSERT_NOW(a_done_not_busy, clock, reset, done_ff, !busy_ff, "sort done while busy")
   `M5SF_ASSERT_NOW(a_count_range, clock, reset, busy_ff, (pass_ff <= PASS_LAST) && (pos_ff <= POS_LAST), "sort counters out of range")
   `M5SF_ASSERT_NEXT(a_start_runs, clock, reset, sort_ctrl.start, busy_ff && (pass_ff == '0) && (pos_ff == '0), "sort did not start")

endmodule

@@ src/median5_setpoint_filter_unit.sv @@
// running median-of-five setpoint filter, top level
// depends on m5sf_pkg, m5sf_sort and median5_setpoint_filter_unit_defines.svh
// result: valid in the cycle after accept when the sample equals the held median,
//    otherwise after 15 ring steps of the shared compare-swap unit, the sort done flag and the update
// flow: a new sample is accepted only in idle, after the previous result has been taken with rsp_ready
// reset: synchronous; window, slot, median, pwm and setpoint registers clear to zero
`timescale 1ns / 1ps
`include "median5_setpoint_filter_unit_defines.svh"

module median5_setpoint_filter_unit
   import m5sf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_pot_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_median_value,
   output pwm_type    rsp_pwm_compare,
   output rpm_type    rsp_rpm_setpoint,
   output logic       rsp_median_changed
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_RESPOND
   } state_type;

   state_type     state_ff, state_in;
   window_type    window_ff, window_in;
   slot_type      slot_ff, slot_in;
   sample_type    held_ff, held_in;
   pwm_type       pwm_ff, pwm_in;
   rpm_type       setpoint_ff, setpoint_in;
   logic          changed_ff, changed_in;

   slot_type      slot_idx;
   slot_type      slot_next;
   window_type    new_window;
   sort_ctrl_type sort_ctrl;
   sort_stat_type sort_stat;
   sample_type    sort_median;

   always_comb begin
      slot_idx = (slot_ff < slot_type'(WINDOW_LEN)) ? slot_ff : '0;
      slot_next = (slot_idx == slot_type'(WINDOW_LEN - 1)) ? '0 : slot_idx + slot_type'(1);
      new_window = window_ff;
      new_window[slot_idx] = req_pot_sample;
   end

   always_comb begin
      state_in        = state_ff;
      window_in       = window_ff;
      slot_in         = slot_ff;
      held_in         = held_ff;
      pwm_in          = pwm_ff;
      setpoint_in     = setpoint_ff;
      changed_in      = changed_ff;
      sort_ctrl.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               window_in = new_window;
               slot_in   = slot_next;
               if (req_pot_sample == held_ff) begin
                  changed_in = 1'b0;
                  state_in   = ST_RESPOND;
               end else begin
                  sort_ctrl.start = 1'b1;
                  state_in        = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (sort_stat.done) begin
               changed_in  = sort_median != held_ff;
               held_in     = sort_median;
               setpoint_in = RPM_LUT[sort_median];
               if (sort_median != held_ff) begin
                  pwm_in = PWM_LUT[sort_median];
               end
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         window_ff   <= '0;
         slot_ff     <= '0;
         held_ff     <= '0;
         pwm_ff      <= '0;
         setpoint_ff <= '0;
         changed_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         window_ff   <= window_in;
         slot_ff     <= slot_in;
         held_ff     <= held_in;
         pwm_ff      <= pwm_in;
         setpoint_ff <= setpoint_in;
         changed_ff  <= changed_in;
      end
   end

   m5sf_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .sort_ctrl (sort_ctrl),
      .window    (new_window),
      .sort_stat (sort_stat),
      .median    (sort_median)
   );

   assign req_ready          = state_ff == ST_IDLE;
   assign rsp_valid          = state_ff == ST_RESPOND;
   assign rsp_median_value   = held_ff;
   assign rsp_pwm_compare    = pwm_ff;
   assign rsp_rpm_setpoint   = setpoint_ff;
   assign rsp_median_changed = changed_ff;

   `M5SF_ASSERT_NOW(a_no_overlap, clock, reset, rsp_valid, !req_ready, "accepting while a result is pending")
   `M5SF_ASSERT_NOW(a_slot_range, clock, reset, 1'b1, slot_ff < slot_type'(WINDOW_LEN), "write slot out of range")
   `M5SF_ASSERT_NOW(a_start_idle, clock, reset, sort_ctrl.start, !sort_stat.busy, "sort started while busy")
   `M5SF_ASSERT_NEXT(a_equal_fast, clock, reset, req_valid && req_ready && (req_pot_sample == held_ff), rsp_valid && !rsp_median_changed, "equal sample did not bypass the sort")
   `M5SF_ASSERT_NOW(a_pwm_match, clock, reset, rsp_valid && rsp_median_changed, rsp_pwm_compare == PWM_LUT[held_ff], "pwm compare does not follow median")

endmodule
